>>> hw/rtl/lkvc_pkg.sv
// Package for the LRU key-value cache: default sizes, command codes, controller states.
// No dependencies; used by lru_key_value_cache_top and its testbench.
package lkvc_pkg;

    localparam int ENTRIES_DEF    = 16;
    localparam int KEY_BITS_DEF   = 16;
    localparam int VALUE_BITS_DEF = 32;

    localparam int          CAP_W     = 5;
    localparam logic [4:0]  CAP_RESET = 5'd16;

    localparam logic CMD_GET = 1'b0;
    localparam logic CMD_PUT = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_SCAN_END,
        ST_DECIDE,
        ST_SWEEP,
        ST_SWEEP_END
    } t_state;

endpackage

>>> hw/rtl/lkvc_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read data.
// No package dependencies.
module lkvc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                 i_clk,
    input  logic                                 i_wr_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]                     i_wr_data,
    input  logic                                 i_rd_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]                     o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> hw/rtl/lru_key_value_cache_top.sv
// Top level of the fully associative LRU key-value cache.
// Depends on lkvc_pkg and lkvc_ram (entry store: key, value and recency age per slot).
//
// A get result is strobed from the decision step, after the scan of every slot.
// A new command is accepted only while idle. A get miss walks the entry RAM once; a get hit
// or any put walks its single read port twice, once to scan and once to rewrite ages.
// Reset (synchronous, active low) clears valid bits, occupancy and control; capacity
// returns to 16. The receiver cannot stall: each result is shown for one cycle only.
module lru_key_value_cache_top #(
    parameter int ENTRIES    = lkvc_pkg::ENTRIES_DEF,
    parameter int KEY_BITS   = lkvc_pkg::KEY_BITS_DEF,
    parameter int VALUE_BITS = lkvc_pkg::VALUE_BITS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // command channel
    input  logic                       start,
    output logic                       busy,
    input  logic                       i_cmd,
    input  logic [KEY_BITS-1:0]        i_key,
    input  logic [VALUE_BITS-1:0]      i_value,
    // results
    output logic                       o_strobe,
    output logic                       o_found,
    output logic [VALUE_BITS-1:0]      o_read_value,
    // capacity register write
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [lkvc_pkg::CAP_W-1:0] i_cfg_capacity
);

    localparam int IDX_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int AGE_W  = IDX_W;
    localparam int OCC_W  = $clog2(ENTRIES + 1);
    localparam int CMP_W  = (OCC_W > lkvc_pkg::CAP_W) ? OCC_W : lkvc_pkg::CAP_W;
    localparam int WORD_W = KEY_BITS + VALUE_BITS + AGE_W;

    // ------------------------------------------------------------------
    // Capacity register and its effective value (zero acts as one,
    // anything above ENTRIES saturates).
    // ------------------------------------------------------------------
    logic [lkvc_pkg::CAP_W-1:0] r_cap;
    logic [CMP_W-1:0]           eff_cap;
    logic [CMP_W-1:0]           cap_ext;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap <= lkvc_pkg::CAP_RESET;
        end else if (i_cfg_valid) begin
            r_cap <= i_cfg_capacity;
        end
    end

    always_comb begin
        cap_ext = CMP_W'(r_cap);
        if (r_cap == '0) begin
            eff_cap = CMP_W'(1);
        end else if (cap_ext > CMP_W'(ENTRIES)) begin
            eff_cap = CMP_W'(ENTRIES);
        end else begin
            eff_cap = cap_ext;
        end
    end

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    lkvc_pkg::t_state r_state, n_state;

    logic [IDX_W-1:0]      r_cnt,       n_cnt;
    logic                  r_cmd,       n_cmd;
    logic [KEY_BITS-1:0]   r_key,       n_key;
    logic [VALUE_BITS-1:0] r_value,     n_value;

    // read pipeline tag: the RAM answers in the cycle after the address
    logic                  r_rd_vld,    n_rd_vld;
    logic                  r_rd_sweep,  n_rd_sweep;
    logic [IDX_W-1:0]      r_rd_addr,   n_rd_addr;

    // scan trackers
    logic                  r_hit,       n_hit;
    logic [IDX_W-1:0]      r_hit_idx,   n_hit_idx;
    logic [AGE_W-1:0]      r_hit_age,   n_hit_age;
    logic [VALUE_BITS-1:0] r_hit_val,   n_hit_val;
    logic                  r_have_lru,  n_have_lru;
    logic [IDX_W-1:0]      r_lru_idx,   n_lru_idx;
    logic [AGE_W-1:0]      r_lru_age,   n_lru_age;
    logic                  r_have_free, n_have_free;
    logic [IDX_W-1:0]      r_free_idx,  n_free_idx;

    // sweep control
    logic [IDX_W-1:0]      r_tgt,       n_tgt;
    logic [AGE_W-1:0]      r_ref_age,   n_ref_age;
    logic                  r_miss,      n_miss;

    logic [ENTRIES-1:0]    r_valid,     n_valid;
    logic [OCC_W-1:0]      r_occ,       n_occ;

    logic                  r_strobe,    n_strobe;
    logic                  r_found,     n_found;
    logic [VALUE_BITS-1:0] r_read_value, n_read_value;

    // RAM ports
    logic                  rd_en;
    logic [IDX_W-1:0]      rd_addr;
    logic [WORD_W-1:0]     rd_data;
    logic                  wr_en;
    logic [IDX_W-1:0]      wr_addr;
    logic [WORD_W-1:0]     wr_data;

    logic [AGE_W-1:0]      rd_age;
    logic [VALUE_BITS-1:0] rd_val;
    logic [KEY_BITS-1:0]   rd_key;
    logic                  rd_entry_valid;
    logic                  evict;
    logic                  is_tgt;
    logic [AGE_W-1:0]      new_age;
    logic [KEY_BITS-1:0]   new_key;
    logic [VALUE_BITS-1:0] new_val;

    assign rd_age         = rd_data[AGE_W-1:0];
    assign rd_val         = rd_data[AGE_W +: VALUE_BITS];
    assign rd_key         = rd_data[AGE_W + VALUE_BITS +: KEY_BITS];
    assign rd_entry_valid = r_valid[r_rd_addr];

    lkvc_ram #(
        .WIDTH (WORD_W),
        .DEPTH (ENTRIES)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= lkvc_pkg::ST_IDLE;
            r_cnt       <= '0;
            r_rd_vld    <= 1'b0;
            r_rd_sweep  <= 1'b0;
            r_hit       <= 1'b0;
            r_have_lru  <= 1'b0;
            r_have_free <= 1'b0;
            r_miss      <= 1'b0;
            r_valid     <= '0;
            r_occ       <= '0;
            r_strobe    <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_rd_vld    <= n_rd_vld;
            r_rd_sweep  <= n_rd_sweep;
            r_hit       <= n_hit;
            r_have_lru  <= n_have_lru;
            r_have_free <= n_have_free;
            r_miss      <= n_miss;
            r_valid     <= n_valid;
            r_occ       <= n_occ;
            r_strobe    <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd        <= n_cmd;
        r_key        <= n_key;
        r_value      <= n_value;
        r_rd_addr    <= n_rd_addr;
        r_hit_idx    <= n_hit_idx;
        r_hit_age    <= n_hit_age;
        r_hit_val    <= n_hit_val;
        r_lru_idx    <= n_lru_idx;
        r_lru_age    <= n_lru_age;
        r_free_idx   <= n_free_idx;
        r_tgt        <= n_tgt;
        r_ref_age    <= n_ref_age;
        r_found      <= n_found;
        r_read_value <= n_read_value;
    end

    // ------------------------------------------------------------------
    // Sweep write-back: the slot read last cycle is rewritten now, so the
    // write always trails the read by one address and never collides.
    // ------------------------------------------------------------------
    always_comb begin
        is_tgt  = (r_rd_addr == r_tgt);
        new_key = (is_tgt && r_miss) ? r_key : rd_key;
        new_val = (is_tgt && (r_cmd == lkvc_pkg::CMD_PUT)) ? r_value : rd_val;
        if (is_tgt) begin
            new_age = '0;
        end else if (r_miss || (rd_age < r_ref_age)) begin
            new_age = rd_age + AGE_W'(1);
        end else begin
            new_age = rd_age;
        end
        wr_en   = r_rd_vld && r_rd_sweep && (is_tgt || rd_entry_valid);
        wr_addr = r_rd_addr;
        wr_data = {new_key, new_val, new_age};
    end

    assign evict = (r_cmd == lkvc_pkg::CMD_PUT) && !r_hit
                   && (CMP_W'(r_occ) >= eff_cap) && (r_occ != '0);

    // ------------------------------------------------------------------
    // Controller: next state, trackers and result
    // ------------------------------------------------------------------
    always_comb begin
        n_state      = r_state;
        n_cnt        = r_cnt;
        n_cmd        = r_cmd;
        n_key        = r_key;
        n_value      = r_value;
        n_hit        = r_hit;
        n_hit_idx    = r_hit_idx;
        n_hit_age    = r_hit_age;
        n_hit_val    = r_hit_val;
        n_have_lru   = r_have_lru;
        n_lru_idx    = r_lru_idx;
        n_lru_age    = r_lru_age;
        n_have_free  = r_have_free;
        n_free_idx   = r_free_idx;
        n_tgt        = r_tgt;
        n_ref_age    = r_ref_age;
        n_miss       = r_miss;
        n_valid      = r_valid;
        n_occ        = r_occ;
        n_strobe     = 1'b0;
        n_found      = r_found;
        n_read_value = r_read_value;
        rd_en        = 1'b0;
        rd_addr      = r_cnt;

        // scan data stage: match, least recent and first free slot
        if (r_rd_vld && !r_rd_sweep) begin
            if (rd_entry_valid) begin
                if (!r_hit && (rd_key == r_key)) begin
                    n_hit     = 1'b1;
                    n_hit_idx = r_rd_addr;
                    n_hit_age = rd_age;
                    n_hit_val = rd_val;
                end
                if (!r_have_lru || (rd_age > r_lru_age)) begin
                    n_have_lru = 1'b1;
                    n_lru_idx  = r_rd_addr;
                    n_lru_age  = rd_age;
                end
            end else if (!r_have_free) begin
                n_have_free = 1'b1;
                n_free_idx  = r_rd_addr;
            end
        end

        unique case (r_state)
            lkvc_pkg::ST_IDLE: begin
                if (start) begin
                    n_cmd       = i_cmd;
                    n_key       = i_key;
                    n_value     = i_value;
                    n_cnt       = '0;
                    n_hit       = 1'b0;
                    n_have_lru  = 1'b0;
                    n_have_free = 1'b0;
                    n_state     = lkvc_pkg::ST_SCAN;
                end
            end
            lkvc_pkg::ST_SCAN, lkvc_pkg::ST_SWEEP: begin
                rd_en = 1'b1;
                n_cnt = r_cnt + IDX_W'(1);
                if (r_cnt == IDX_W'(ENTRIES - 1)) begin
                    n_cnt   = '0;
                    n_state = (r_state == lkvc_pkg::ST_SCAN) ? lkvc_pkg::ST_SCAN_END
                                                             : lkvc_pkg::ST_SWEEP_END;
                end
            end
            lkvc_pkg::ST_SCAN_END: begin
                n_state = lkvc_pkg::ST_DECIDE;
            end
            lkvc_pkg::ST_DECIDE: begin
                n_cnt     = '0;
                n_ref_age = r_hit_age;
                n_miss    = (r_cmd == lkvc_pkg::CMD_PUT) && !r_hit;
                n_state   = lkvc_pkg::ST_SWEEP;
                if (r_cmd == lkvc_pkg::CMD_GET) begin
                    n_strobe     = 1'b1;
                    n_found      = r_hit;
                    n_read_value = r_hit ? r_hit_val : '0;
                    if (!r_hit) begin
                        n_state = lkvc_pkg::ST_IDLE;
                    end
                    n_tgt = r_hit_idx;
                end else if (r_hit) begin
                    n_tgt = r_hit_idx;
                end else if (evict) begin
                    // victim slot is reused in place, occupancy unchanged
                    n_tgt              = r_lru_idx;
                    n_valid[r_lru_idx] = 1'b1;
                end else begin
                    n_tgt               = r_free_idx;
                    n_valid[r_free_idx] = 1'b1;
                    n_occ               = r_occ + OCC_W'(1);
                end
            end
            lkvc_pkg::ST_SWEEP_END: begin
                n_state = lkvc_pkg::ST_IDLE;
            end
            default: begin
                n_state = lkvc_pkg::ST_IDLE;
            end
        endcase

        n_rd_vld   = rd_en;
        n_rd_sweep = (r_state == lkvc_pkg::ST_SWEEP);
        n_rd_addr  = rd_addr;
    end

    assign busy         = (r_state != lkvc_pkg::ST_IDLE);
    assign o_strobe     = r_strobe;
    assign o_found      = r_found;
    assign o_read_value = r_read_value;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_occ_matches_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(r_valid) == int'(r_occ))
        else $error("occupancy out of step with valid bits");

    a_no_rw_collision: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (wr_en && rd_en) |-> (wr_addr != rd_addr))
        else $error("entry RAM read and write to the same slot");

    a_strobe_from_decide: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(r_state == lkvc_pkg::ST_DECIDE))
        else $error("result strobe outside decision step");

    a_idle_pipe_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !busy |-> !r_rd_vld)
        else $error("RAM read pending while idle");

endmodule

>>> tb/sv/lru_key_value_cache_top_test.sv
// Self-checking testbench for lru_key_value_cache_top: directed and random get/put items
// are checked against a recency-ranked cache model kept alongside the block.
// Depends on lkvc_pkg and the cache RTL only.
module lru_key_value_cache_top_test;

    localparam int ENTRIES  = lkvc_pkg::ENTRIES_DEF;
    localparam int KEY_W    = lkvc_pkg::KEY_BITS_DEF;
    localparam int VAL_W    = lkvc_pkg::VALUE_BITS_DEF;
    localparam int CAP_W    = lkvc_pkg::CAP_W;
    // cycles with nothing accepted before the run is abandoned; the slowest item
    // (hit or put) plus a gap or the inter-phase pause
    // is well under a tenth of this
    localparam int STALL_LIMIT = 1000;
    // pause after the last result: a put gives no strobe, so allow a full put pass
    localparam int DRAIN_CYCLES = 2 * ENTRIES + 8;

    typedef struct {
        logic             cmd;
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] value;
    } t_cache_op;

    typedef struct {
        logic             found;
        logic [VAL_W-1:0] value;
    } t_lookup;

    logic             i_clk          = 1'b0;
    logic             i_rst_n        = 1'b0;
    logic             start          = 1'b0;
    logic             busy;
    logic             i_cmd          = lkvc_pkg::CMD_GET;
    logic [KEY_W-1:0] i_key          = '0;
    logic [VAL_W-1:0] i_value        = '0;
    logic             o_strobe;
    logic             o_found;
    logic [VAL_W-1:0] o_read_value;
    logic             i_cfg_valid    = 1'b0;
    logic             o_cfg_ready;
    logic [CAP_W-1:0] i_cfg_capacity = '0;

    // model of the cache contents; rank 0 = most recent
    logic [KEY_W-1:0] slot_key  [ENTRIES];
    logic [VAL_W-1:0] slot_val  [ENTRIES];
    logic             slot_used [ENTRIES] = '{default: 1'b0};
    int               slot_rank [ENTRIES] = '{default: 0};
    int               fill_count = 0;
    logic [CAP_W-1:0] cap_reg    = lkvc_pkg::CAP_RESET;

    t_cache_op pending_ops[$];        // items waiting to be presented
    t_lookup   expected_lookups[$];   // get results not yet strobed
    t_cache_op next_op;
    t_lookup   oldest_lookup;

    int   gap_left     = 0;
    bit   no_gaps      = 1'b0;
    int   stall_cycles = 0;
    int   fail_count   = 0;

    lru_key_value_cache_top u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_cmd          (i_cmd),
        .i_key          (i_key),
        .i_value        (i_value),
        .o_strobe       (o_strobe),
        .o_found        (o_found),
        .o_read_value   (o_read_value),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_capacity (i_cfg_capacity)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Cache model
    // ------------------------------------------------------------------

    // zero behaves as one, anything past the array size saturates
    function automatic int usable_capacity();
        if (cap_reg == 0) return 1;
        if (cap_reg > ENTRIES) return ENTRIES;
        return int'(cap_reg);
    endfunction

    function automatic int slot_of(logic [KEY_W-1:0] k);
        for (int s = 0; s < ENTRIES; s++)
            if (slot_used[s] && slot_key[s] == k) return s;
        return -1;
    endfunction

    // move a slot to the front; only the entries that were ahead of it age
    function automatic void promote(int s);
        int r;
        r = slot_rank[s];
        for (int j = 0; j < ENTRIES; j++)
            if (slot_used[j] && slot_rank[j] < r) slot_rank[j]++;
        slot_rank[s] = 0;
    endfunction

    // first slot holding the highest rank wins ties
    function automatic int stalest_slot();
        int  best;
        bit  have;
        best = 0;
        have = 1'b0;
        for (int j = 0; j < ENTRIES; j++) begin
            if (slot_used[j] && (!have || slot_rank[j] > slot_rank[best])) begin
                best = j;
                have = 1'b1;
            end
        end
        return best;
    endfunction

    function automatic int first_free_slot();
        for (int j = 0; j < ENTRIES; j++)
            if (!slot_used[j]) return j;
        return 0;
    endfunction

    // apply one accepted item to the model; a get queues the lookup it should return
    task automatic predict_op(logic cmd, logic [KEY_W-1:0] k, logic [VAL_W-1:0] v);
        int      s;
        t_lookup want;
        s = slot_of(k);
        if (cmd == lkvc_pkg::CMD_GET) begin
            want.found = (s >= 0);
            want.value = (s >= 0) ? slot_val[s] : '0;
            if (s >= 0) promote(s);
            expected_lookups.push_back(want);
        end else if (s >= 0) begin
            slot_val[s] = v;
            promote(s);
        end else begin
            // a lowered capacity still only evicts one entry per miss
            if (fill_count >= usable_capacity() && fill_count > 0) begin
                s = stalest_slot();
                slot_used[s] = 1'b0;
                fill_count--;
            end else begin
                s = first_free_slot();
            end
            for (int j = 0; j < ENTRIES; j++)
                if (slot_used[j]) slot_rank[j]++;
            slot_key[s]  = k;
            slot_val[s]  = v;
            slot_used[s] = 1'b1;
            slot_rank[s] = 0;
            fill_count++;
        end
    endtask

    // ------------------------------------------------------------------
    // Driver: start held until busy is low at an edge. The gap before the next
    // item counts only idle cycles, the accepting edge among them, so a gap spent
    // by that edge holds start high while busy; a longer one lands on an idle block.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (start && !busy) begin
                predict_op(i_cmd, i_key, i_value);
                gap_left = no_gaps ? 0 : $urandom_range(0, 4);
            end
            if (!start || !busy) begin
                if (gap_left == 0 && pending_ops.size() != 0) begin
                    next_op = pending_ops.pop_front();
                    start   <= 1'b1;
                    i_cmd   <= next_op.cmd;
                    i_key   <= next_op.key;
                    i_value <= next_op.value;
                end else begin
                    if (gap_left != 0 && !busy) gap_left--;
                    start <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: every strobe must match the oldest outstanding get
    // ------------------------------------------------------------------
    task automatic report_mismatch(string what, logic [VAL_W-1:0] got,
                                   logic [VAL_W-1:0] want);
        $display("MISMATCH at %0t: %s got %0h expected %0h", $realtime, what, got, want);
        fail_count++;
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe) begin
            if (expected_lookups.size() == 0) begin
                report_mismatch("result with no get outstanding", o_read_value, '0);
            end else begin
                oldest_lookup = expected_lookups.pop_front();
                if (o_found !== oldest_lookup.found)
                    report_mismatch("found", VAL_W'(o_found), VAL_W'(oldest_lookup.found));
                if (o_read_value !== oldest_lookup.value)
                    report_mismatch("read_value", o_read_value, oldest_lookup.value);
            end
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: any accepted item, result or register write counts as progress
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if ((start && !busy) || o_strobe || (i_cfg_valid && o_cfg_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
    end

    initial begin
        while (stall_cycles < STALL_LIMIT) @(posedge i_clk);
        $display("Verification failed");
        $finish;
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic push_op(logic cmd, logic [KEY_W-1:0] k, logic [VAL_W-1:0] v);
        t_cache_op op;
        op.cmd   = cmd;
        op.key   = k;
        op.value = v;
        pending_ops.push_back(op);
    endtask

    // wait for every item to go in and every get to come back, then let a
    // trailing put finish its age sweep so the block is idle
    task automatic settle();
        while (pending_ops.size() != 0 || start || expected_lookups.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_capacity(logic [CAP_W-1:0] cap);
        @(posedge i_clk);
        i_cfg_valid    <= 1'b1;
        i_cfg_capacity <= cap;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        cap_reg = cap;
    endtask

    // mostly keys from a small pool so hits, updates and evictions are frequent;
    // the rest are arbitrary keys that nearly always miss
    task automatic random_phase(int count);
        logic [KEY_W-1:0] pool [24];
        logic [KEY_W-1:0] k;
        foreach (pool[i]) pool[i] = KEY_W'($urandom_range(0, 16'hFFFF));
        for (int n = 0; n < count; n++) begin
            if ($urandom_range(0, 99) < 85)
                k = pool[$urandom_range(0, 23)];
            else
                k = KEY_W'($urandom_range(0, 16'hFFFF));
            push_op($urandom_range(0, 1) ? lkvc_pkg::CMD_PUT : lkvc_pkg::CMD_GET, k,
                    VAL_W'($urandom()));
        end
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial begin
        logic [CAP_W-1:0] phase_caps [8];

        phase_caps = '{5'd1, 5'd16, 5'd17, 5'd0, 5'd31, 5'd3, 5'd0, 5'd0};
        phase_caps[6] = CAP_W'($urandom_range(0, 31));
        phase_caps[7] = CAP_W'($urandom_range(0, 31));

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset capacity of 16: empty lookup, key and value extremes, update in place
        push_op(lkvc_pkg::CMD_GET, 16'h0000, 32'h0);
        push_op(lkvc_pkg::CMD_PUT, 16'h0000, 32'h0000_0000);
        push_op(lkvc_pkg::CMD_PUT, 16'hFFFF, 32'hFFFF_FFFF);
        push_op(lkvc_pkg::CMD_GET, 16'h0000, 32'hFFFF_FFFF);
        push_op(lkvc_pkg::CMD_GET, 16'hFFFF, 32'h0);
        push_op(lkvc_pkg::CMD_PUT, 16'hFFFF, 32'h5A5A_A5A5);
        push_op(lkvc_pkg::CMD_GET, 16'hFFFF, 32'h0);
        push_op(lkvc_pkg::CMD_GET, 16'h1234, 32'h0);
        // fill to sixteen, then one more put pushes out key 0
        for (int i = 0; i < 14; i++)
            push_op(lkvc_pkg::CMD_PUT, KEY_W'(16'h0100 + i), VAL_W'(32'hC000_0000 | i));
        push_op(lkvc_pkg::CMD_PUT, 16'h0200, 32'h8000_0001);
        push_op(lkvc_pkg::CMD_GET, 16'h0000, 32'h0);
        push_op(lkvc_pkg::CMD_GET, 16'h0101, 32'h0);
        settle();

        // capacity dropped below occupancy: misses swap one entry, hits untouched
        write_capacity(5'd2);
        push_op(lkvc_pkg::CMD_PUT, 16'h0300, 32'h1111_2222);
        push_op(lkvc_pkg::CMD_GET, 16'h0300, 32'h0);
        push_op(lkvc_pkg::CMD_GET, 16'h0105, 32'h0);
        push_op(lkvc_pkg::CMD_PUT, 16'h0301, 32'h3333_4444);
        push_op(lkvc_pkg::CMD_GET, 16'h0200, 32'h0);
        settle();

        // zero behaves as one entry
        write_capacity(5'd0);
        push_op(lkvc_pkg::CMD_PUT, 16'h0400, 32'hAAAA_5555);
        push_op(lkvc_pkg::CMD_PUT, 16'h0401, 32'h5555_AAAA);
        push_op(lkvc_pkg::CMD_GET, 16'h0401, 32'h0);
        push_op(lkvc_pkg::CMD_GET, 16'h0400, 32'h0);
        settle();

        // random phases over a spread of capacities, some without any gaps
        for (int ph = 0; ph < 8; ph++) begin
            write_capacity(phase_caps[ph]);
            no_gaps = (ph % 3 == 1);
            random_phase(120);
            settle();
        end

        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
